// ----- design/smcs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smcs_pkg
// Shared types and constants for the sparse matrix coordinate store.
// ----------------------------------------------------------------------------
package smcs_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int MAX_DIM      = 1024;

    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int TOTAL_W = 7;
    localparam int DIM_W   = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_SUM   = 2'd2,
        CMD_COUNT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [VAL_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  result_value;
        status_t                  status;
        logic [TOTAL_W-1:0]       entry_total;
    } rsp_t;

    // One stored nonzero entry
    typedef struct packed {
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic [VAL_W-1:0]         value;
    } slot_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage : smcs_pkg
`default_nettype wire

// ----- design/smcs_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smcs_ctrl
// Sequencer: take one request, run the slot scan, commit the result.
// ----------------------------------------------------------------------------
module smcs_ctrl
    import smcs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                // hold until the output register can take the result
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign cmd.load   = (state_reg == S_IDLE) && in_valid;
    assign cmd.scan   = (state_reg == S_SCAN);
    assign cmd.commit = (state_reg == S_COMMIT) && stat.out_free;

endmodule : smcs_ctrl
`default_nettype wire

// ----- design/smcs_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smcs_dp
// Datapath: slot memory, fill count, scan compare, accumulator, size
// registers and the output register.
// ----------------------------------------------------------------------------
module smcs_dp
    import smcs_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctrl_cmd_t             cmd,
    output dp_stat_t                   stat,
    input  wire req_t                  in_data,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [DIM_W-1:0]      cfg_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output rsp_t                       out_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // Slots fill from the bottom and are never freed, so slot i is in use
    // exactly when i < count_reg.
    slot_t mem [CAPACITY];

    req_t                req_reg;
    logic [DIM_W-1:0]    num_rows_reg;
    logic [DIM_W-1:0]    num_cols_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       idx_reg;
    logic                chk_vld_reg;
    slot_t               rd_data_reg;
    logic [AW-1:0]       rd_idx_reg;
    logic                match_reg;
    logic [AW-1:0]       match_idx_reg;
    logic [VAL_W-1:0]    acc_reg;
    logic                out_vld_reg;
    rsp_t                out_reg;
    rsp_t                out_next;

    logic                row_ok;
    logic                col_ok;
    logic                rng_ok;
    logic                need_scan;
    logic                issue;
    logic                hit_row;
    logic                hit;
    logic                is_write;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic                insert;
    logic [CW+TOTAL_W-1:0] total_ext;

    assign row_ok = ({1'b0, req_reg.row} < num_rows_reg) && (32'(req_reg.row) < MAX_DIM);
    assign col_ok = ({1'b0, req_reg.col} < num_cols_reg) && (32'(req_reg.col) < MAX_DIM);

    always_comb
    begin
        unique case (req_reg.cmd)
            CMD_SUM:   rng_ok = row_ok;
            CMD_COUNT: rng_ok = 1'b1;
            default:   rng_ok = row_ok && col_ok;
        endcase
    end

    assign is_write  = (req_reg.cmd == CMD_WRITE);
    // count needs no scan, nor does a zero write or an out-of-range request
    assign need_scan = (req_reg.cmd != CMD_COUNT) && rng_ok
                       && !(is_write && (req_reg.value == '0));
    assign issue     = cmd.scan && need_scan && (idx_reg < count_reg);

    assign hit_row = (rd_data_reg.row == req_reg.row);
    assign hit     = hit_row && (rd_data_reg.col == req_reg.col);

    assign insert = cmd.commit && is_write && need_scan && !match_reg
                    && (count_reg != CAP_CNT);
    assign mem_we = cmd.commit && is_write && need_scan
                    && (match_reg || (count_reg != CAP_CNT));
    assign mem_wa = match_reg ? match_idx_reg : count_reg[AW-1:0];

    assign count_next = insert ? count_reg + CW'(1) : count_reg;
    assign total_ext  = {{TOTAL_W{1'b0}}, count_next};

    always_comb
    begin
        out_next.entry_total = total_ext[TOTAL_W-1:0];
        if ((req_reg.cmd == CMD_READ) || (req_reg.cmd == CMD_SUM))
        begin
            out_next.result_value = acc_reg;
        end
        else
        begin
            out_next.result_value = '0;
        end
        if (!rng_ok)
        begin
            out_next.status = ST_RANGE;
        end
        else if (is_write && need_scan && !match_reg && (count_reg == CAP_CNT))
        begin
            out_next.status = ST_FULL;
        end
        else
        begin
            out_next.status = ST_OK;
        end
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= '{row: req_reg.row, col: req_reg.col, value: req_reg.value};
        end
        if (issue)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
            rd_idx_reg  <= idx_reg[AW-1:0];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_data;
        end
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
        if (cmd.load)
        begin
            acc_reg <= '0;
        end
        else if (chk_vld_reg)
        begin
            if (req_reg.cmd == CMD_SUM)
            begin
                if (hit_row)
                begin
                    acc_reg <= acc_reg + rd_data_reg.value;
                end
            end
            else if (hit)
            begin
                acc_reg       <= rd_data_reg.value;
                match_idx_reg <= rd_idx_reg;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= DIM_RESET;
            num_cols_reg <= DIM_RESET;
            count_reg    <= '0;
            idx_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            match_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_NUM_ROWS: num_rows_reg <= cfg_data;
                    REG_NUM_COLS: num_cols_reg <= cfg_data;
                    default:      ;
                endcase
            end
            count_reg   <= count_next;
            chk_vld_reg <= issue;
            if (cmd.load)
            begin
                idx_reg   <= '0;
                match_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
                if (chk_vld_reg && (req_reg.cmd != CMD_SUM) && hit)
                begin
                    match_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_vld_reg && !out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign stat.scan_done = !(need_scan && (idx_reg < count_reg));
    assign stat.out_free  = !out_vld_reg || !out_stall;

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule : smcs_dp
`default_nettype wire

// ----- design/sparse_matrix_coordinate_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_matrix_coordinate_store
// Bounded coordinate-list store of nonzero matrix entries with write, read,
// row sum and count requests.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------
//   in       | in_valid/in_stall  | in_data  (cmd, row, col, value)
//   out      | out_valid/out_stall| out_data (result_value, status, total)
//   cfg      | cfg_valid/cfg_ready| cfg_index, cfg_data (num_rows/cols)
//
// One request at a time. The scan reads one slot per cycle through the single
// memory read port, one read per stored entry. The next request is accepted
// once the result is registered and the sequencer is back in idle.
// Count, out-of-range and zero-write requests skip the scan.
// Reset clears the fill count; no memory clearing pass is needed.
// A result held by out_stall does not block acceptance of the next request;
// that request then holds in commit until the output register frees.
// ----------------------------------------------------------------------------
module sparse_matrix_coordinate_store
    import smcs_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire req_t                  in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output rsp_t                       out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [DIM_W-1:0]      cfg_data
);

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    assign cfg_ready = 1'b1;

    smcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    smcs_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctrl_cmd),
        .stat      (dp_stat),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule : sparse_matrix_coordinate_store
`default_nettype wire
